// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication: pre holds -> post holds at this edge.
`define ASSERT_IMPLY(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("websocket deframer check failed");
// Next-cycle implication: pre holds -> post holds at the following edge.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("websocket deframer check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, pre, post)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== rtl/core/wsd_pkg.sv =====
// Shared types, status codes and helpers for the WebSocket frame deframer.
// No dependencies; imported by the parser, the result queue and the top level.
package wsd_pkg;

  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [3:0] OPC_TEXT = 4'h1;

  typedef enum logic [2:0] {
    ST_TEXT     = 3'd0,
    ST_OTHER    = 3'd1,
    ST_TRUNC    = 3'd2,
    ST_NOTFIN   = 3'd3,
    ST_UNMASKED = 3'd4,
    ST_TOOLARGE = 3'd5
  } wsd_status_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [3:0]  opcode;
    logic [15:0] length;
  } wsd_result_t;

  // Up to two results produced by one input transfer; slot 0 fills first.
  typedef struct packed {
    logic        v0;
    logic        v1;
    wsd_result_t r0;
    wsd_result_t r1;
  } wsd_push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] fill;
    logic              room2;
  } wsd_qstat_t;

  function automatic wsd_result_t mk_status(wsd_status_t st, logic [3:0] opc,
                                            logic [15:0] len);
    wsd_result_t r;
    r.kind   = KIND_STATUS;
    r.data   = 8'h00;
    r.status = st;
    r.opcode = opc;
    r.length = len;
    return r;
  endfunction

  function automatic wsd_result_t mk_data(logic [7:0] d, logic [3:0] opc,
                                          logic [15:0] len);
    wsd_result_t r;
    r.kind   = KIND_DATA;
    r.data   = d;
    r.status = ST_TEXT;
    r.opcode = opc;
    r.length = len;
    return r;
  endfunction

endpackage

// ===== rtl/core/wsd_parser.sv =====
// Header parser and payload unmasker: frame state plus per-byte decode.
// Depends on wsd_pkg; produces up to two results per accepted byte.
module wsd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic [7:0]        rx_byte,
  input  logic              end_of_buffer,
  output wsd_pkg::wsd_push_t push
);
  import wsd_pkg::*;

  typedef enum logic [6:0] {
    PH_HDR0    = 7'b0000001,
    PH_HDR1    = 7'b0000010,
    PH_EXT_HI  = 7'b0000100,
    PH_EXT_LO  = 7'b0001000,
    PH_MASK    = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_DONE    = 7'b1000000
  } wsd_phase_t;

  wsd_phase_t  phase_r,  phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] pos_r,    pos_nxt;
  logic [31:0] mask_r,   mask_nxt;
  logic        fin_r,    fin_nxt;

  logic [6:0]  len7;
  logic [15:0] pos_inc;
  logic [7:0]  key;
  wsd_status_t done_st;
  wsd_result_t trunc_res;
  wsd_push_t   res;

  assign len7    = rx_byte[6:0];
  assign pos_inc = pos_r + 16'd1;
  assign done_st = (opcode_r == OPC_TEXT) ? ST_TEXT : ST_OTHER;

  // Key byte for this payload position, first key byte at position 0.
  always_comb begin
    unique case (pos_r[1:0])
      2'd0: key = mask_r[31:24];
      2'd1: key = mask_r[23:16];
      2'd2: key = mask_r[15:8];
      2'd3: key = mask_r[7:0];
      default: key = 8'h00;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    length_nxt = length_r;
    pos_nxt    = pos_r;
    mask_nxt   = mask_r;
    fin_nxt    = fin_r;
    res        = '0;
    trunc_res  = '0;

    unique case (phase_r)
      PH_HDR0: begin
        opcode_nxt = rx_byte[3:0];
        fin_nxt    = rx_byte[7];
        phase_nxt  = PH_HDR1;
      end
      PH_HDR1: begin
        mask_nxt   = '0;
        length_nxt = (len7 < 7'd126) ? {9'd0, len7} : 16'd0;
        if (!fin_r) begin
          res.v0    = 1'b1;
          res.r0    = mk_status(ST_NOTFIN, opcode_r, length_nxt);
          phase_nxt = PH_DONE;
        end else if (!rx_byte[7]) begin
          res.v0    = 1'b1;
          res.r0    = mk_status(ST_UNMASKED, opcode_r, length_nxt);
          phase_nxt = PH_DONE;
        end else if (len7 == 7'd127) begin
          res.v0    = 1'b1;
          res.r0    = mk_status(ST_TOOLARGE, opcode_r, 16'd0);
          phase_nxt = PH_DONE;
        end else if (len7 == 7'd126) begin
          phase_nxt = PH_EXT_HI;
        end else begin
          pos_nxt   = '0;
          phase_nxt = PH_MASK;
        end
      end
      PH_EXT_HI: begin
        length_nxt = {rx_byte, 8'h00};
        phase_nxt  = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        length_nxt = length_r | {8'h00, rx_byte};
        pos_nxt    = '0;
        phase_nxt  = PH_MASK;
      end
      PH_MASK: begin
        mask_nxt = {mask_r[23:0], rx_byte};
        pos_nxt  = pos_inc;
        if (pos_inc >= 16'd4) begin
          pos_nxt = '0;
          if (length_r == 16'd0) begin
            res.v0    = 1'b1;
            res.r0    = mk_status(done_st, opcode_r, length_r);
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res.v0  = 1'b1;
        res.r0  = mk_data(rx_byte ^ key, opcode_r, length_r);
        pos_nxt = pos_inc;
        if (pos_inc >= length_r) begin
          res.v1    = 1'b1;
          res.r1    = mk_status(done_st, opcode_r, length_r);
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
        // drop trailing bytes until the buffer ends
      end
      default: begin
        phase_nxt = PH_HDR0;
      end
    endcase

    // End of buffer: report an unfinished frame, then return to reset state.
    if (end_of_buffer) begin
      if (phase_nxt != PH_DONE) begin
        trunc_res = mk_status(ST_TRUNC, opcode_nxt, length_nxt);
        if (res.v0) begin
          res.v1 = 1'b1;
          res.r1 = trunc_res;
        end else begin
          res.v0 = 1'b1;
          res.r0 = trunc_res;
        end
      end
      phase_nxt  = PH_HDR0;
      opcode_nxt = '0;
      length_nxt = '0;
      pos_nxt    = '0;
      mask_nxt   = '0;
      fin_nxt    = 1'b0;
    end

    push    = res;
    push.v0 = res.v0 & in_accept;
    push.v1 = res.v1 & in_accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= '0;
      length_r <= '0;
      pos_r    <= '0;
      mask_r   <= '0;
      fin_r    <= 1'b0;
    end else if (in_accept) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      length_r <= length_nxt;
      pos_r    <= pos_nxt;
      mask_r   <= mask_nxt;
      fin_r    <= fin_nxt;
    end
  end

endmodule

// ===== rtl/core/wsd_out_queue.sv =====
// Result queue: shift register of results, up to two pushed and one popped
// per cycle. Depends on wsd_pkg.
module wsd_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wsd_pkg::wsd_push_t   push,
  input  logic                 pop_ready,
  output wsd_pkg::wsd_result_t head,
  output logic                 head_valid,
  output wsd_pkg::wsd_qstat_t  qstat
);
  import wsd_pkg::*;

  wsd_result_t       q_r [QDEPTH];
  wsd_result_t       q_nxt [QDEPTH];
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [QCNT_W-1:0] base;
  logic              pop;

  assign head_valid  = (count_r != '0);
  assign head        = q_r[0];
  assign pop         = head_valid & pop_ready;
  assign base        = count_r - {{(QCNT_W-1){1'b0}}, pop};
  assign qstat.fill  = count_r;
  assign qstat.room2 = (count_r <= QCNT_W'(QDEPTH - 2));

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    // advance toward the head on a pop
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (push.v0 && (base == QCNT_W'(i))) begin
        q_nxt[i] = push.r0;
      end
      if (push.v1 && ((base + QCNT_W'(1)) == QCNT_W'(i))) begin
        q_nxt[i] = push.r1;
      end
    end
    count_nxt = base + {{(QCNT_W-1){1'b0}}, push.v0}
                     + {{(QCNT_W-1){1'b0}}, push.v1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
// Top level of the WebSocket client frame deframer: parser plus result queue.
// Depends on wsd_pkg, wsd_parser, wsd_out_queue and assert_macros.svh.
//
//  channel | dir | tdata                               | tuser | tlast
//  --------+-----+-------------------------------------+-------+--------------
//  in_     | in  | [7:0] rx_byte                       |  -    | end_of_buffer
//  out_    | out | [7:0] data_byte, [10:8] status,     | kind  |  -
//          |     | [14:11] frame_opcode, [30:15] length|       |
//
// One received byte per cycle while in_tready is high: each input transfer is decoded in the same
// cycle by the parser and its results (none for most header and key bytes, one,
// or two at the end of a frame or on an early end of buffer) land in a
// four-entry result queue. The queue drains one result per cycle while out_tready
// is high, so bytes flow at one per clock while the output keeps up; in_tready
// drops only in reset or while the queue cannot take two more results.
// Reset (rst_n low at a clock edge) returns the parser to the first header
// byte and empties the queue; in_tready is held low while rst_n is low.
// A stalled output holds its head result stable.
`include "assert_macros.svh"

module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // received byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // end_of_buffer
  // decoded results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data_byte, [10:8] status,
                                  // [14:11] frame_opcode, [30:15] frame_length
  output logic        out_tuser   // kind: 0 payload byte, 1 frame status
);
  import wsd_pkg::*;

  logic        in_accept;
  wsd_push_t   push;
  wsd_result_t head;
  logic        head_valid;
  wsd_qstat_t  qstat;

  // Take a byte only out of reset and when the queue has room for both
  // results it may cause.
  assign in_tready = rst_n & qstat.room2;
  assign in_accept = in_tvalid & in_tready;

  wsd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .rx_byte       (in_tdata),
    .end_of_buffer (in_tlast),
    .push          (push)
  );

  wsd_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop_ready  (out_tready),
    .head       (head),
    .head_valid (head_valid),
    .qstat      (qstat)
  );

  // Pack the head result for the output transfer.
  assign out_tvalid = head_valid;
  assign out_tuser  = head.kind;
  assign out_tdata  = {1'b0, head.length, head.opcode, head.status, head.data};

  // The queue never overfills.
  `ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, qstat.fill <= QCNT_W'(QDEPTH))
  // A second result is only ever produced behind a first one.
  `ASSERT_IMPLY(a_pair_order, clk, rst_n, push.v1, push.v0)
  // A result pushed into an empty queue is offered in the next cycle.
  `ASSERT_NEXT(a_push_shows, clk, rst_n, push.v0 && (qstat.fill == '0), out_tvalid)

endmodule
